/* src/ffpa_pkg.sv */
// shared types and constants for the first-fit partition allocator
// no dependencies; imported by ffpa_ctrl, ffpa_dp and the top level
`default_nettype none

package ffpa_pkg;

  // table geometry
  localparam int MAX_PARTITIONS = 64;
  localparam int IDX_W          = 6;
  localparam int CNT_W          = $clog2(MAX_PARTITIONS + 1);

  // item field widths
  localparam int FUNC_W = 2;
  localparam int SIZE_W = 16;
  localparam int STAT_W = 3;
  localparam int REQ_W  = 7;
  localparam int OUT_DATA_W = 16;

  localparam logic [REQ_W-1:0] REQ_MAX = '1;

  // operation codes carried on the input tuser
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_ALLOC = 2'd1,
    FUNC_CLEAR = 2'd2
  } ffpa_func_t;

  // result status codes carried on the output tuser
  typedef enum logic [STAT_W-1:0] {
    ST_LOADED  = 3'd0,
    ST_GRANTED = 3'd1,
    ST_NOFIT   = 3'd2,
    ST_STOPPED = 3'd3,
    ST_FULL    = 3'd4,
    ST_CLEARED = 3'd5
  } ffpa_status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } ffpa_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic scan_step;
    logic commit;
  } ffpa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              stopped;
    logic              hit;
    logic              miss;
    logic              out_free;
  } ffpa_stat_t;

endpackage

`default_nettype wire

/* src/ffpa_ctrl.sv */
// controller state machine for the first-fit partition allocator
// depends on ffpa_pkg; drives ffpa_dp through ffpa_cmd_t
`default_nettype none

module ffpa_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ffpa_pkg::ffpa_stat_t stat,
  output ffpa_pkg::ffpa_cmd_t      cmd
);
  import ffpa_pkg::*;

  ffpa_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd.accept    = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.commit    = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.func)
          FUNC_LOAD, FUNC_CLEAR: state_next = S_DONE;
          FUNC_ALLOC:            state_next = stat.stopped ? S_DONE : S_SCAN;
          default:               state_next = S_IDLE;  // unused code, no result
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.hit || stat.miss) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* src/ffpa_dp.sv */
// datapath: capacity memory, used bits, counters, scan pipeline, output register
// depends on ffpa_pkg; commanded by ffpa_ctrl
`default_nettype none

module ffpa_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire ffpa_pkg::ffpa_cmd_t                 cmd,
  output ffpa_pkg::ffpa_stat_t                     stat,
  input  wire logic [ffpa_pkg::FUNC_W-1:0]         in_func,
  input  wire logic [ffpa_pkg::SIZE_W-1:0]         in_size,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [ffpa_pkg::STAT_W-1:0]              out_status,
  output logic [ffpa_pkg::IDX_W-1:0]               out_slot,
  output logic [ffpa_pkg::REQ_W-1:0]               out_reqno
);
  import ffpa_pkg::*;

  // captured item
  logic [FUNC_W-1:0] func;
  logic [SIZE_W-1:0] size;

  // table state
  logic [SIZE_W-1:0]         cap_mem [MAX_PARTITIONS];
  logic [MAX_PARTITIONS-1:0] used;
  logic [CNT_W-1:0]          pcount;
  logic [REQ_W-1:0]          req_cnt;
  logic                      stopped;

  // scan pipeline
  logic [CNT_W-1:0]  scan_addr;
  logic [IDX_W-1:0]  cmp_idx;
  logic              cmp_valid;
  logic [SIZE_W-1:0] rd_data;
  logic              used_rd;
  logic              found;
  logic [IDX_W-1:0]  found_idx;

  logic              issue;
  logic              hit;
  logic              full;
  logic [REQ_W-1:0]  req_inc;
  logic              out_free;

  assign issue    = cmd.scan_step && (scan_addr < pcount);
  assign hit      = cmp_valid && !used_rd && (rd_data >= size);
  assign full     = (pcount >= CNT_W'(MAX_PARTITIONS));
  assign req_inc  = (req_cnt == REQ_MAX) ? req_cnt : req_cnt + 1'b1;
  assign out_free = !out_valid || out_ready;

  assign stat.func     = func;
  assign stat.stopped  = stopped;
  assign stat.hit      = hit;
  assign stat.miss     = (scan_addr >= pcount) && !hit;
  assign stat.out_free = out_free;

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func <= in_func;
      size <= in_size;
    end
  end

  // capacity memory: write on load commit, registered read during scan
  always_ff @(posedge clk) begin
    if (cmd.commit && func == FUNC_LOAD && !full) begin
      cap_mem[pcount[IDX_W-1:0]] <= size;
    end
  end

  // used flags are read alongside the capacity; they only change at commit
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= cap_mem[scan_addr[IDX_W-1:0]];
      used_rd <= used[scan_addr[IDX_W-1:0]];
    end
  end

  // scan address, compare stage and first hit
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      cmp_valid <= 1'b0;
      found     <= 1'b0;
    end else if (cmd.accept) begin
      scan_addr <= '0;
      cmp_valid <= 1'b0;
      found     <= 1'b0;
    end else if (cmd.scan_step) begin
      cmp_valid <= issue;
      if (issue) begin
        scan_addr <= scan_addr + 1'b1;
      end
      if (hit) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      cmp_idx <= scan_addr[IDX_W-1:0];
    end
    if (cmd.scan_step && hit) begin
      found_idx <= cmp_idx;
    end
  end

  // used flags: a load clears the entry it appends, so entries at or above
  // the partition count are never read and need no clearing
  always_ff @(posedge clk) begin
    if (!rst && cmd.commit) begin
      if (func == FUNC_LOAD && !full) begin
        used[pcount[IDX_W-1:0]] <= 1'b0;
      end else if (func == FUNC_ALLOC && !stopped && found) begin
        used[found_idx] <= 1'b1;
      end
    end
  end

  // counters and stop flag update at commit
  always_ff @(posedge clk) begin
    if (rst) begin
      pcount  <= '0;
      req_cnt <= '0;
      stopped <= 1'b0;
    end else if (cmd.commit) begin
      case (func)
        FUNC_LOAD: begin
          if (!full) begin
            pcount <= pcount + 1'b1;
          end
        end
        FUNC_ALLOC: begin
          req_cnt <= req_inc;
          if (!stopped && !found) begin
            stopped <= 1'b1;
          end
        end
        FUNC_CLEAR: begin
          pcount  <= '0;
          req_cnt <= '0;
          stopped <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_slot  <= '0;
      out_reqno <= '0;
      case (func)
        FUNC_LOAD: begin
          out_status <= full ? ST_FULL : ST_LOADED;
        end
        FUNC_ALLOC: begin
          out_reqno <= req_inc;
          if (stopped) begin
            out_status <= ST_STOPPED;
          end else if (found) begin
            out_status <= ST_GRANTED;
            out_slot   <= found_idx;
          end else begin
            out_status <= ST_NOFIT;
          end
        end
        default: begin
          out_status <= ST_CLEARED;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/first_fit_partition_allocator_top.sv */
// top level of the first-fit partition allocator
// depends on ffpa_pkg, ffpa_ctrl and ffpa_dp
//
//   channel   direction  tdata                              tuser
//   s_axis    in         [15:0] size_value                  [1:0] func
//   m_axis    out        [5:0] slot_index, [12:6] req num   [2:0] status
//
// one item at a time; a load, clear or stopped request goes from accept through the
// exec and done states into the output register, and the next item is taken in idle
// an allocate scan reads one capacity per cycle and ends at the first unused partition
// whose capacity is at least the size, or after the last loaded partition
// the output register holds a result while the next item is accepted; that item
// then waits with tready low until the result leaves; rst is synchronous
`default_nettype none

module first_fit_partition_allocator_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [ffpa_pkg::SIZE_W-1:0]       s_axis_tdata,  // [15:0] size_value
  input  wire logic [ffpa_pkg::FUNC_W-1:0]       s_axis_tuser,  // [1:0] func
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [ffpa_pkg::OUT_DATA_W-1:0]        m_axis_tdata,  // [5:0] slot_index, [12:6] request_number
  output logic [ffpa_pkg::STAT_W-1:0]            m_axis_tuser   // [2:0] status
);
  import ffpa_pkg::*;

  ffpa_cmd_t         cmd;
  ffpa_stat_t        stat;
  logic [IDX_W-1:0]  out_slot;
  logic [REQ_W-1:0]  out_reqno;

  // controller
  ffpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  ffpa_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_func    (s_axis_tuser),
    .in_size    (s_axis_tdata),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (m_axis_tuser),
    .out_slot   (out_slot),
    .out_reqno  (out_reqno)
  );

  // pack result fields, zero fill to whole bytes
  assign m_axis_tdata = {{(OUT_DATA_W - IDX_W - REQ_W){1'b0}}, out_reqno, out_slot};

endmodule

`default_nettype wire
